// File: hw/rtl/keyed_min_max_priority_store_unit_defines.svh
// Assertion macros used by the priority store checker.
`ifndef KEYED_MIN_MAX_PRIORITY_STORE_UNIT_DEFINES_SVH
`define KEYED_MIN_MAX_PRIORITY_STORE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KMM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kmm assertion failed");

// Next-cycle implication, disabled while reset is high.
`define KMM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kmm assertion failed");

`endif

// File: hw/rtl/kmm_pkg.sv
// Types and constants of the keyed min/max priority store.
package kmm_pkg;

   localparam int CAPACITY   = 64;
   localparam int ID_BITS    = 17;
   localparam int LEVEL_BITS = 7;
   localparam int KEY_BITS   = ID_BITS + LEVEL_BITS;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_QUERY  = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_REINSERT
   } fsm_type;

   typedef struct packed {
      mode_type                mode;
      logic [ID_BITS-1:0]      entry_id;
      logic [LEVEL_BITS-1:0]   entry_level;
      logic                    want_greatest;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0] result_id;
      status_type         status;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [ID_BITS-1:0]    id;
      logic [LEVEL_BITS-1:0] level;
   } entry_type;

   // Summary of the chain seen by the control logic.
   typedef struct packed {
      logic               any_match;
      logic               full;
      logic               empty;
      logic [ID_BITS-1:0] least_id;
      logic [ID_BITS-1:0] greatest_id;
   } chain_status_type;

endpackage

// File: hw/rtl/keyed_min_max_priority_store_unit.sv
// Results: a result is registered in the cycle after its request is accepted; an add
// of an identifier already present is done as a remove, then a sorted reinsert in the
// REINSERT state, and its result is registered after the reinsert. Throughput: one
// request per cycle while the response is taken and no re-add is pending; a re-add updates the cell row twice.
// Reset: synchronous, active high; all cells empty, no result pending.
module keyed_min_max_priority_store_unit import kmm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   fsm_type          state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   entry_type        pend_ff, pend_in;
   logic             rsp_load;
   logic             req_fire;
   cell_op_type      cell_op;
   entry_type        cmd_entry;
   chain_status_type chain_status;

   assign req_ready = (state_ff == FSM_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   kmm_chain u_chain (
      .clock        (clock),
      .reset        (reset),
      .cell_op      (cell_op),
      .cmd_entry    (cmd_entry),
      .chain_status (chain_status)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_fire && (req_data.mode == MODE_ADD) && chain_status.any_match) begin
               state_in = FSM_REINSERT;
            end
         end
         FSM_REINSERT: begin
            state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd_entry   = '{valid: 1'b1, id: req_data.entry_id, level: req_data.entry_level};
      cell_op     = CELL_HOLD;
      rsp_load    = 1'b0;
      rsp_data_in = '{result_id: '0, status: STATUS_OK};
      pend_in     = pend_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               rsp_load = 1'b1;
               unique case (req_data.mode)
                  MODE_ADD: begin
                     if (chain_status.any_match) begin
                        // drop the old entry now, put it back with the new level next
                        cell_op  = CELL_REMOVE;
                        pend_in  = cmd_entry;
                        rsp_load = 1'b0;
                     end else if (chain_status.full) begin
                        rsp_data_in.status = STATUS_FULL;
                     end else begin
                        cell_op = CELL_INSERT;
                     end
                  end
                  MODE_QUERY: begin
                     if (chain_status.empty) begin
                        rsp_data_in.status = STATUS_EMPTY;
                     end else if (req_data.want_greatest) begin
                        rsp_data_in.result_id = chain_status.greatest_id;
                     end else begin
                        rsp_data_in.result_id = chain_status.least_id;
                     end
                  end
                  MODE_REMOVE: begin
                     cell_op = CELL_REMOVE;
                  end
                  default: begin
                     cell_op = CELL_HOLD;
                  end
               endcase
            end
         end
         FSM_REINSERT: begin
            cmd_entry = pend_ff;
            cell_op   = CELL_INSERT;
            rsp_load  = 1'b1;
         end
         default: begin
            cell_op = CELL_HOLD;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
      pend_ff <= pend_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/kmm_cell.sv
// One cell of the sorted entry chain.
module kmm_cell import kmm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cell_op_type cell_op,
   input  entry_type   cmd_entry,
   input  entry_type   left_entry,
   input  logic        left_above,
   input  entry_type   right_entry,
   input  logic        hit_in,
   output entry_type   cell_entry,
   output logic        above,
   output logic        hit_out
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      match;

   assign match   = entry_ff.valid && (entry_ff.id == cmd_entry.id);
   assign hit_out = hit_in | match;
   // empty cells sort above everything, so a new entry lands at the first cell that sorts above it
   assign above   = !entry_ff.valid ||
                    ({entry_ff.level, entry_ff.id} > {cmd_entry.level, cmd_entry.id});

   always_comb begin
      entry_in = entry_ff;
      unique case (cell_op)
         CELL_INSERT: begin
            if (left_above) begin
               entry_in = left_entry;
            end else if (above) begin
               entry_in = cmd_entry;
            end
         end
         CELL_REMOVE: begin
            if (hit_out) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.id    <= entry_in.id;
      entry_ff.level <= entry_in.level;
   end

   assign cell_entry = entry_ff;

endmodule

// File: hw/rtl/kmm_chain.sv
// Row of sorted cells, least entry at cell 0, valid cells packed low.
module kmm_chain import kmm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cell_op_type      cell_op,
   input  entry_type        cmd_entry,
   output chain_status_type chain_status
);

   entry_type cells[CAPACITY];
   logic      above[CAPACITY];
   logic      hit[CAPACITY];
   logic [ID_BITS-1:0] greatest_id;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_above;
      logic      hit_in;

      if (g == 0) begin : g_first
         assign left_entry = '0;
         assign left_above = 1'b0;
         assign hit_in     = 1'b0;
      end else begin : g_inner
         assign left_entry = cells[g-1];
         assign left_above = above[g-1];
         assign hit_in     = hit[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_mid
         assign right_entry = cells[g+1];
      end

      kmm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_op     (cell_op),
         .cmd_entry   (cmd_entry),
         .left_entry  (left_entry),
         .left_above  (left_above),
         .right_entry (right_entry),
         .hit_in      (hit_in),
         .cell_entry  (cells[g]),
         .above       (above[g]),
         .hit_out     (hit[g])
      );
   end

   // greatest entry is the last valid cell
   always_comb begin
      greatest_id = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cells[i].valid && ((i == CAPACITY - 1) || !cells[(i + 1) % CAPACITY].valid)) begin
            greatest_id = greatest_id | cells[i].id;
         end
      end
   end

   assign chain_status.any_match   = hit[CAPACITY-1];
   assign chain_status.full        = cells[CAPACITY-1].valid;
   assign chain_status.empty       = !cells[0].valid;
   assign chain_status.least_id    = cells[0].id;
   assign chain_status.greatest_id = greatest_id;

endmodule

// File: hw/rtl/kmm_checker.sv
// Port-level checks for the priority store, bound to the top level.
`include "keyed_min_max_priority_store_unit_defines.svh"

module kmm_checker import kmm_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic rsp_stall;
   logic req_plain;
   logic rsp_not_ok;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   // every request but an add answers on the next cycle
   assign req_plain  = req_valid && req_ready && (req_data.mode != MODE_ADD);
   assign rsp_not_ok = rsp_valid && (rsp_data.status != STATUS_OK);

   `KMM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `KMM_ASSERT_NOW(a_no_accept_when_blocked, clock, reset, rsp_stall, !req_ready)
   `KMM_ASSERT_NEXT(a_single_cycle_result, clock, reset, req_plain, rsp_valid)
   `KMM_ASSERT_NOW(a_id_zero_unless_ok, clock, reset, rsp_not_ok, rsp_data.result_id == '0)

endmodule

bind keyed_min_max_priority_store_unit kmm_checker u_kmm_checker (.*);
